// File: src/hslc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslc_pkg
// Shared types and constants for the HSL to RGB colour converter.
// ----------------------------------------------------------------------------
package hslc_pkg;

    // Field widths
    localparam int HUE_W   = 9;
    localparam int PCT_W   = 7;
    localparam int CHAN_W  = 8;
    localparam int FIX_W   = 14;   // levels in 1/10000, 0..10000
    localparam int FRAC_W  = 6;    // segment position, 0..60
    localparam int LEVEL_W = 20;   // level in 1/600000, 0..600000
    localparam int SUM_W   = 28;   // level * 255 + half step
    localparam int QUOT_W  = 22;   // sum / 64
    localparam int RECIP_W = 23;
    localparam int RECIP_SH = 36;

    // Percent scale and fixed-point limits
    localparam logic [PCT_W-1:0]   PCT_MAX    = 7'd100;
    localparam logic [PCT_W-1:0]   PCT_SCALE  = 7'd100;
    localparam logic [FIX_W-1:0]   FIX_HALF   = 14'd5000;

    // Hue sectors in degrees
    localparam logic [HUE_W-1:0]   DEG_360    = 9'd360;
    localparam logic [HUE_W-1:0]   DEG_240    = 9'd240;
    localparam logic [HUE_W-1:0]   DEG_180    = 9'd180;
    localparam logic [HUE_W-1:0]   DEG_120    = 9'd120;
    localparam logic [HUE_W-1:0]   DEG_60     = 9'd60;
    localparam logic [FRAC_W-1:0]  SEG_FULL   = 6'd60;

    // Output scaling: round(level * 255 / 600000)
    localparam logic [LEVEL_W-1:0] LEVEL_MUL60 = 20'd60;
    localparam logic [SUM_W-1:0]   CHAN_MAXV   = 28'd255;
    localparam logic [SUM_W-1:0]   ROUND_HALF  = 28'd300000;
    // ceil(2^36 / 9375): exact quotient for every sum / 64 in range
    localparam logic [RECIP_W-1:0] RECIP_9375  = 23'd7330078;

    typedef struct packed {
        logic [HUE_W-1:0] hue_deg;
        logic [PCT_W-1:0] sat_pct;
        logic [PCT_W-1:0] light_pct;
    } hsl_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    // Per-stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } hslc_en_t;

endpackage

// File: src/hslc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslc_front
// Stages 1 and 2: clamping, hue sectors and the hi / lo levels.
// ----------------------------------------------------------------------------
module hslc_front (
    input  logic                           clk,
    input  hslc_pkg::hslc_en_t             en,
    input  hslc_pkg::hsl_t                 hsl,
    output logic [hslc_pkg::FIX_W-1:0]     lo,
    output logic [hslc_pkg::FIX_W-1:0]     diff,
    output logic [hslc_pkg::FRAC_W-1:0]    x_red,
    output logic [hslc_pkg::FRAC_W-1:0]    x_green,
    output logic [hslc_pkg::FRAC_W-1:0]    x_blue
);
    import hslc_pkg::*;

    function automatic logic [FRAC_W-1:0] seg_pos(input logic [HUE_W-1:0] a);
        logic [HUE_W-1:0] t;
        t = DEG_240 - a;
        if (a < DEG_60)
            seg_pos = a[FRAC_W-1:0];
        else if (a < DEG_180)
            seg_pos = SEG_FULL;
        else if (a < DEG_240)
            seg_pos = t[FRAC_W-1:0];
        else
            seg_pos = '0;
    endfunction

    logic [PCT_W-1:0]   sat_c;
    logic [PCT_W-1:0]   light_c;
    logic [HUE_W-1:0]   hue_m;
    logic [HUE_W:0]     a_r_sum;
    logic [HUE_W:0]     a_b_sum;
    logic [HUE_W-1:0]   a_red;
    logic [HUE_W-1:0]   a_blue;

    logic [PCT_W-1:0]   sat_reg;
    logic [PCT_W-1:0]   light_reg;
    logic [FIX_W-1:0]   prod_reg;
    logic [FRAC_W-1:0]  xr1_reg, xg1_reg, xb1_reg;

    logic [FIX_W-1:0]   big_l;
    logic [FIX_W-1:0]   big_s;
    logic [FIX_W:0]     hi_w;
    logic [FIX_W:0]     lo_w;
    logic [FIX_W-1:0]   hi_next;
    logic [FIX_W-1:0]   lo_next;

    logic [FIX_W-1:0]   lo_reg;
    logic [FIX_W-1:0]   diff_reg;
    logic [FRAC_W-1:0]  xr2_reg, xg2_reg, xb2_reg;

    // Stage 1: clamp, reduce hue, channel angles
    always_comb
    begin
        sat_c   = (hsl.sat_pct   > PCT_MAX) ? PCT_MAX : hsl.sat_pct;
        light_c = (hsl.light_pct > PCT_MAX) ? PCT_MAX : hsl.light_pct;
        hue_m   = (hsl.hue_deg >= DEG_360) ? (hsl.hue_deg - DEG_360) : hsl.hue_deg;
        a_r_sum = {1'b0, hue_m} + {1'b0, DEG_120};
        a_b_sum = {1'b0, hue_m} + {1'b0, DEG_240};
        a_red   = (a_r_sum >= {1'b0, DEG_360}) ? HUE_W'(a_r_sum - {1'b0, DEG_360})
                                              : a_r_sum[HUE_W-1:0];
        a_blue  = (a_b_sum >= {1'b0, DEG_360}) ? HUE_W'(a_b_sum - {1'b0, DEG_360})
                                              : a_b_sum[HUE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            sat_reg   <= sat_c;
            light_reg <= light_c;
            prod_reg  <= FIX_W'(sat_c) * FIX_W'(light_c);
            xr1_reg   <= seg_pos(a_red);
            xg1_reg   <= seg_pos(hue_m);
            xb1_reg   <= seg_pos(a_blue);
        end
    end

    // Stage 2: hi and lo levels in 1/10000
    always_comb
    begin
        big_l   = FIX_W'(light_reg) * FIX_W'(PCT_SCALE);
        big_s   = FIX_W'(sat_reg) * FIX_W'(PCT_SCALE);
        if (big_l < FIX_HALF)
            hi_w = {1'b0, big_l} + {1'b0, prod_reg};
        else
            hi_w = {1'b0, big_l} + {1'b0, big_s} - {1'b0, prod_reg};
        hi_next = hi_w[FIX_W-1:0];
        lo_w    = {big_l, 1'b0} - {1'b0, hi_next};
        lo_next = lo_w[FIX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            lo_reg   <= lo_next;
            diff_reg <= hi_next - lo_next;
            xr2_reg  <= xr1_reg;
            xg2_reg  <= xg1_reg;
            xb2_reg  <= xb1_reg;
        end
    end

    assign lo      = lo_reg;
    assign diff    = diff_reg;
    assign x_red   = xr2_reg;
    assign x_green = xg2_reg;
    assign x_blue  = xb2_reg;

endmodule

// File: src/hslc_chan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslc_chan
// Stages 3 to 5 of one colour channel: level, rounding sum, scale to 8 bits.
// ----------------------------------------------------------------------------
module hslc_chan (
    input  logic                           clk,
    input  hslc_pkg::hslc_en_t             en,
    input  logic [hslc_pkg::FIX_W-1:0]     lo,
    input  logic [hslc_pkg::FIX_W-1:0]     diff,
    input  logic [hslc_pkg::FRAC_W-1:0]    x,
    output logic [hslc_pkg::CHAN_W-1:0]    chan
);
    import hslc_pkg::*;

    localparam int PROD_W = QUOT_W + RECIP_W;

    logic [LEVEL_W-1:0] level_reg;
    logic [QUOT_W-1:0]  quot_reg;
    logic [CHAN_W-1:0]  chan_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [PROD_W-1:0]  recip_prod;

    // Stage 3: level = 60*lo + (hi-lo)*x
    always_ff @(posedge clk)
    begin
        if (en.s3)
            level_reg <= LEVEL_W'(lo) * LEVEL_MUL60 + LEVEL_W'(diff) * LEVEL_W'(x);
    end

    // Stage 4: level*255 plus half a step, pre-divided by 64
    assign sum_next = SUM_W'(level_reg) * CHAN_MAXV + ROUND_HALF;

    always_ff @(posedge clk)
    begin
        if (en.s4)
            quot_reg <= sum_next[SUM_W-1:6];
    end

    // Stage 5: divide by 9375 through the reciprocal
    assign recip_prod = PROD_W'(quot_reg) * PROD_W'(RECIP_9375);

    always_ff @(posedge clk)
    begin
        if (en.s5)
            chan_reg <= recip_prod[RECIP_SH+CHAN_W-1:RECIP_SH];
    end

    assign chan = chan_reg;

endmodule

// File: src/hsl_to_rgb_converter.sv
`timescale 1ns / 1ps
// An accepted hsl transaction passes each register stage in order to rgb_valid; stalls can hold it.
// Throughput: one transaction per cycle unless stalled; five register stages, the last
// being the output register, each with its own valid bit so empty stages fill during a stall.
// Reset: rst_n clears all stage valid bits asynchronously; data registers are not reset.
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// Pipelined HSL to 8-bit RGB colour conversion with valid/ready handshakes.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            hsl_valid,
    output logic            hsl_ready,
    input  hslc_pkg::hsl_t  hsl,
    output logic            rgb_valid,
    input  logic            rgb_ready,
    output hslc_pkg::rgb_t  rgb
);
    import hslc_pkg::*;

    localparam int NSTG = 5;

    logic [NSTG:1]     valid_reg;
    logic [NSTG+1:1]   stg_ready;
    logic [NSTG:0]     stg_in_valid;
    hslc_en_t          en;

    logic [FIX_W-1:0]  lo;
    logic [FIX_W-1:0]  diff;
    logic [FRAC_W-1:0] x_red, x_green, x_blue;

    // Ready ripples back; a stage loads when empty or its successor moves
    always_comb
    begin
        stg_ready[NSTG+1] = rgb_ready;
        for (int k = NSTG; k >= 1; k--)
            stg_ready[k] = !valid_reg[k] || stg_ready[k+1];
        stg_in_valid = {valid_reg, hsl_valid};
        en.s1 = stg_ready[1] && stg_in_valid[0];
        en.s2 = stg_ready[2] && stg_in_valid[1];
        en.s3 = stg_ready[3] && stg_in_valid[2];
        en.s4 = stg_ready[4] && stg_in_valid[3];
        en.s5 = stg_ready[5] && stg_in_valid[4];
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            for (int k = 1; k <= NSTG; k++)
                if (stg_ready[k])
                    valid_reg[k] <= stg_in_valid[k-1];
        end
    end

    hslc_front u_front (
        .clk     (clk),
        .en      (en),
        .hsl     (hsl),
        .lo      (lo),
        .diff    (diff),
        .x_red   (x_red),
        .x_green (x_green),
        .x_blue  (x_blue)
    );

    hslc_chan u_red (
        .clk  (clk),
        .en   (en),
        .lo   (lo),
        .diff (diff),
        .x    (x_red),
        .chan (rgb.red)
    );

    hslc_chan u_green (
        .clk  (clk),
        .en   (en),
        .lo   (lo),
        .diff (diff),
        .x    (x_green),
        .chan (rgb.green)
    );

    hslc_chan u_blue (
        .clk  (clk),
        .en   (en),
        .lo   (lo),
        .diff (diff),
        .x    (x_blue),
        .chan (rgb.blue)
    );

    assign hsl_ready = stg_ready[1];
    assign rgb_valid = valid_reg[NSTG];

endmodule

// File: src/hslc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslc_checker
// Port-level checks on the converter: handshake hold, back-pressure and occupancy.
// ----------------------------------------------------------------------------
module hslc_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            hsl_valid,
    input  logic            hsl_ready,
    input  logic            rgb_valid,
    input  logic            rgb_ready,
    input  hslc_pkg::rgb_t  rgb
);
    import hslc_pkg::*;

    localparam int DEPTH = 5;

    logic [2:0] occ_reg;
    logic [2:0] occ_next;
    logic       take_in;
    logic       take_out;

    // Transactions in flight
    assign take_in  = hsl_valid && hsl_ready;
    assign take_out = rgb_valid && rgb_ready;

    always_comb
    begin
        occ_next = occ_reg;
        if (take_in && !take_out)
            occ_next = occ_reg + 3'd1;
        else if (take_out && !take_in)
            occ_next = occ_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && !rgb_ready |=> rgb_valid && $stable(rgb))
        else $error("rgb result changed while stalled");

    // Free output side never back-pressures the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!rgb_valid || rgb_ready) |-> hsl_ready)
        else $error("input stalled with output free");

    // Never more transactions in flight than stages
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= 3'(DEPTH))
        else $error("more transactions in flight than pipeline stages");

    // No result without an accepted input
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid |-> occ_reg != 3'd0)
        else $error("rgb result with nothing in flight");

    // Full pipeline refuses input unless the output moves
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == 3'(DEPTH)) && !rgb_ready |-> !hsl_ready)
        else $error("input taken into a full pipeline");

endmodule

bind hsl_to_rgb_converter hslc_checker u_hslc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .hsl_valid (hsl_valid),
    .hsl_ready (hsl_ready),
    .rgb_valid (rgb_valid),
    .rgb_ready (rgb_ready),
    .rgb       (rgb)
);
